[hdl/smf_pkg.sv]
// shared constants and types of the sliding mean filter
`default_nettype none

package smf_pkg;

  // width of the mean field of a result word
  localparam int MEAN_W = 16;

  // status of the divider as seen by the control logic
  typedef struct packed {
    logic busy;   // division steps in progress
    logic done;   // quotient ready and held until taken
  } div_status_t;

endpackage

`default_nettype wire

[hdl/smf_if.sv]
// valid/ready channel interfaces for sample and result words
`default_nettype none

interface smf_in_if #(
  parameter int SAMPLE_WIDTH = 16
);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface smf_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [smf_pkg::MEAN_W-1:0] mean_value;
  logic                              window_full;

  modport source (output valid, output mean_value, output window_full, input ready);
  modport sink   (input valid, input mean_value, input window_full, output ready);
endinterface

`default_nettype wire

[hdl/smf_cell.sv]
// one window cell: holds a sample and passes it on when a new word shifts in
`default_nettype none

module smf_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           shift_i,
  input  wire logic signed [SAMPLE_WIDTH-1:0] data_i,
  output      logic signed [SAMPLE_WIDTH-1:0] data_o
);

  logic signed [SAMPLE_WIDTH-1:0] data_q;

  // window starts out as all zero samples
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      data_q <= '0;
    end else if (shift_i) begin
      data_q <= data_i;
    end
  end

  assign data_o = data_q;

endmodule

`default_nettype wire

[hdl/smf_div.sv]
// restoring divider, one quotient bit per cycle, truncates toward zero
`default_nettype none

module smf_div #(
  parameter int SUM_W = 20,
  parameter int DIV_W = 5
) (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    start_i,
  input  wire logic signed [SUM_W-1:0] dividend_i,
  input  wire logic        [DIV_W-1:0] divisor_i,
  input  wire logic                    take_i,
  output      smf_pkg::div_status_t    status_o,
  output      logic signed [SUM_W-1:0] quot_o
);

  localparam int CNT_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e             state_q;
  logic [CNT_W-1:0]   step_q;
  logic               neg_q;
  logic [SUM_W-1:0]   mag_q;
  logic [DIV_W-1:0]   rem_q;
  logic [DIV_W-1:0]   den_q;

  logic [SUM_W-1:0]   din_u;
  logic [SUM_W-1:0]   abs_in;
  logic [DIV_W:0]     trial;
  logic [DIV_W:0]     diff;
  logic               fits;
  logic [DIV_W-1:0]   rem_next;

  assign din_u  = dividend_i;
  assign abs_in = din_u[SUM_W-1] ? (~din_u + SUM_W'(1)) : din_u;

  // shift in the next dividend bit and try a subtraction
  assign trial    = {rem_q, mag_q[SUM_W-1]};
  assign diff     = trial - {1'b0, den_q};
  assign fits     = (trial >= {1'b0, den_q});
  assign rem_next = fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      step_q  <= '0;
      neg_q   <= 1'b0;
      mag_q   <= '0;
      rem_q   <= '0;
      den_q   <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            neg_q   <= din_u[SUM_W-1];
            mag_q   <= abs_in;
            rem_q   <= '0;
            den_q   <= divisor_i;
            step_q  <= CNT_W'(SUM_W - 1);
            state_q <= S_RUN;
          end
        end
        S_RUN: begin
          rem_q <= rem_next;
          mag_q <= {mag_q[SUM_W-2:0], fits};
          if (step_q == '0) begin
            state_q <= S_DONE;
          end else begin
            step_q <= step_q - CNT_W'(1);
          end
        end
        S_DONE: begin
          if (take_i) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign status_o.busy = (state_q == S_RUN);
  assign status_o.done = (state_q == S_DONE);
  assign quot_o        = neg_q ? signed'(~mag_q + SUM_W'(1)) : signed'(mag_q);

endmodule

`default_nettype wire

[hdl/sliding_mean_filter_core.sv]
// sliding mean filter top level: cell chain window, running sum and divider
//
// usage
//   in_i carries one signed sample word per transfer (valid/ready), out_o
//   delivers one result word per sample: the mean of the window, truncated
//   toward zero, and a window_full flag
//   the window is a row of WINDOW_LENGTH cells; each accepted sample shifts
//   in at the head and the oldest drops off the tail, its value subtracted
//   from the running sum while the new one is added
//   during warm-up the divisor is the number of samples seen so far, the
//   current one included; from the WINDOW_LENGTH-th sample on it is
//   WINDOW_LENGTH and window_full reads 1
//   result path: the new sum, SUM_W = SAMPLE_WIDTH + clog2(WINDOW_LENGTH)
//   bits wide, goes to the divider, which retires one quotient bit per
//   cycle and holds the quotient until the output register takes it
//   a sample is not taken while the last one is still in the divider; the
//   next sample is taken once the quotient moves into the output register,
//   even if that word still waits for the receiver
//   receiver stall: the result word holds in the output register and a
//   finished quotient waits in the divider, which blocks new samples
//   reset: all cells, the running sum and the fill count go to zero
`default_nettype none

module sliding_mean_filter_core #(
  parameter int WINDOW_LENGTH = 16,
  parameter int SAMPLE_WIDTH  = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  smf_in_if.sink     in_i,
  smf_out_if.source  out_o
);

  localparam int SUM_W = SAMPLE_WIDTH + $clog2(WINDOW_LENGTH);
  localparam int IDX_W = $clog2(WINDOW_LENGTH);
  localparam int DIV_W = $clog2(WINDOW_LENGTH + 1);

  // window cells, tap zero is the incoming sample, the last tap the oldest
  logic signed [SAMPLE_WIDTH-1:0] tap [WINDOW_LENGTH+1];

  // running sum and warm-up tracking
  logic signed [SUM_W-1:0] sum_q;
  logic signed [SUM_W-1:0] sum_d;
  logic [IDX_W-1:0]        count_q;
  logic                    filled_q;
  logic [DIV_W-1:0]        seen;
  logic                    fill_hit;
  logic [DIV_W-1:0]        divisor;

  // handshakes
  logic in_fire;
  logic out_load;

  // divider
  smf_pkg::div_status_t    div_st;
  logic signed [SUM_W-1:0] quot;

  // output register
  logic                              out_valid_q;
  logic signed [smf_pkg::MEAN_W-1:0] mean_q;
  logic                              full_q;

  // new samples only while the divider is free
  assign in_i.ready = !div_st.busy && !div_st.done;
  assign in_fire    = in_i.valid && in_i.ready;

  // cell chain
  assign tap[0] = in_i.sample;

  for (genvar k = 0; k < WINDOW_LENGTH; k++) begin : g_cell
    smf_cell #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .shift_i (in_fire),
      .data_i  (tap[k]),
      .data_o  (tap[k+1])
    );
  end

  // drop the oldest sample, add the new one
  assign sum_d = sum_q - SUM_W'(tap[WINDOW_LENGTH]) + SUM_W'(in_i.sample);

  // samples seen including this one; the window fills on the last slot
  assign seen     = DIV_W'(count_q) + DIV_W'(1);
  assign fill_hit = (seen == DIV_W'(WINDOW_LENGTH));
  assign divisor  = (filled_q || fill_hit) ? DIV_W'(WINDOW_LENGTH) : seen;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q    <= '0;
      count_q  <= '0;
      filled_q <= 1'b0;
    end else if (in_fire) begin
      sum_q <= sum_d;
      if (!filled_q) begin
        if (fill_hit) begin
          filled_q <= 1'b1;
          count_q  <= '0;
        end else begin
          count_q <= seen[IDX_W-1:0];
        end
      end
    end
  end

  smf_div #(
    .SUM_W (SUM_W),
    .DIV_W (DIV_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (in_fire),
    .dividend_i (sum_d),
    .divisor_i  (divisor),
    .take_i     (out_load),
    .status_o   (div_st),
    .quot_o     (quot)
  );

  // move the quotient on when the output register is free or being emptied
  assign out_load = div_st.done && (!out_valid_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // result payload, wrapped to the mean width
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      mean_q <= smf_pkg::MEAN_W'(quot);
      full_q <= filled_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.mean_value  = mean_q;
  assign out_o.window_full = full_q;

  // an accepted sample always starts a division
  a_start_div : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> div_st.busy)
    else $error("divider did not start after a sample was accepted");

  // once filled, the window stays filled
  a_filled_sticky : assert property (@(posedge clk_i) disable iff (!rst_ni)
    filled_q |=> filled_q)
    else $error("window full flag cleared without reset");

  // a finished quotient reaches an empty output register in the following cycle
  a_result_moves : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (div_st.done && !out_valid_q) |=> (out_valid_q && !div_st.done))
    else $error("finished quotient not moved to the output register");

endmodule

`default_nettype wire
